/* rtl/core/assert_macros.svh */
// Assertion macros shared by the core RTL.
// Concurrent checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define GF2C_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GF2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GF2C_ASSERT(lbl, clk, rst_n, prop, msg)
`define GF2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/core/gf2c_pkg.sv */
// Package for the sparse GF(2) column adder: sizes, opcodes and cell command type.
// No dependencies.
`timescale 1ns / 1ps

package gf2c_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int INDEX_BITS  = 20;
  localparam int POS_BITS    = $clog2(MAX_ENTRIES);
  localparam int SIZE_BITS   = $clog2(MAX_ENTRIES + 1);
  localparam int PIVOT_BITS  = INDEX_BITS + 1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TOGGLE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [SIZE_BITS-1:0]  size_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic del;
  } gf2c_cmd_t;

endpackage

/* rtl/core/gf2c_if.sv */
// Valid/ready channel interfaces for the column adder input and result streams.
// Depends on gf2c_pkg.
`timescale 1ns / 1ps

interface gf2c_in_if import gf2c_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  idx_t       entry_index;
  pos_t       position;

  modport source (output valid, output opcode, output entry_index, output position,
                  input ready);
  modport sink   (input valid, input opcode, input entry_index, input position,
                  output ready);
endinterface

interface gf2c_out_if import gf2c_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [PIVOT_BITS-1:0] pivot;
  size_t                        size;
  idx_t                         read_value;
  logic                         overflow;

  modport source (output valid, output pivot, output size, output read_value,
                  output overflow, input ready);
  modport sink   (input valid, input pivot, input size, input read_value,
                  input overflow, output ready);
endinterface

/* rtl/core/gf2c_cell.sv */
// One storage cell of the sorted index chain: holds an entry and its valid bit,
// compares it with the operand and shifts left or right on insert/delete. Uses gf2c_pkg.
`timescale 1ns / 1ps

module gf2c_cell import gf2c_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  gf2c_cmd_t cmd,
  input  idx_t      v,
  input  idx_t      left_entry,
  input  logic      left_valid,
  input  logic      left_lt,
  input  idx_t      right_entry,
  input  logic      right_valid,
  output idx_t      entry,
  output logic      valid,
  output logic      lt,
  output logic      eq
);

  idx_t entry_r, entry_nxt;
  logic valid_r, valid_nxt;

  assign lt    = valid_r && (entry_r < v);
  assign eq    = valid_r && (entry_r == v);
  assign entry = entry_r;
  assign valid = valid_r;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (cmd.clr) begin
      valid_nxt = 1'b0;
    end else if (cmd.ins && !lt) begin
      if (left_lt) begin
        entry_nxt = v;
        valid_nxt = 1'b1;
      end else begin
        entry_nxt = left_entry;
        valid_nxt = left_valid;
      end
    end else if (cmd.del && !lt) begin
      entry_nxt = right_entry;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* rtl/core/gf2c_chain.sv */
// Row of gf2c_cell instances with neighbor wiring and the match, last-entry
// and positional read reductions. Depends on gf2c_pkg and gf2c_cell.
`timescale 1ns / 1ps

module gf2c_chain import gf2c_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  gf2c_cmd_t cmd,
  input  idx_t      v,
  input  pos_t      rd_pos,
  output logic      found,
  output logic      first_valid,
  output idx_t      last_entry,
  output idx_t      rd_entry
);

  idx_t                   entry_w [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_w;
  logic [MAX_ENTRIES-1:0] lt_w;
  logic [MAX_ENTRIES-1:0] eq_w;
  logic [MAX_ENTRIES-1:0] last_w;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    idx_t l_entry, r_entry;
    logic l_valid, l_lt, r_valid;

    if (k == 0) begin : g_left_edge
      assign l_entry = '0;
      assign l_valid = 1'b0;
      assign l_lt    = 1'b1;
    end else begin : g_left
      assign l_entry = entry_w[k-1];
      assign l_valid = valid_w[k-1];
      assign l_lt    = lt_w[k-1];
    end

    if (k == MAX_ENTRIES - 1) begin : g_right_edge
      assign r_entry = '0;
      assign r_valid = 1'b0;
    end else begin : g_right
      assign r_entry = entry_w[k+1];
      assign r_valid = valid_w[k+1];
    end

    gf2c_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .v           (v),
      .left_entry  (l_entry),
      .left_valid  (l_valid),
      .left_lt     (l_lt),
      .right_entry (r_entry),
      .right_valid (r_valid),
      .entry       (entry_w[k]),
      .valid       (valid_w[k]),
      .lt          (lt_w[k]),
      .eq          (eq_w[k])
    );
  end

  assign found       = |eq_w;
  assign first_valid = valid_w[0];
  assign last_w      = valid_w & ~(valid_w >> 1);

  always_comb begin
    last_entry = '0;
    rd_entry   = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (last_w[k]) begin
        last_entry = last_entry | entry_w[k];
      end
      if (valid_w[k] && (rd_pos == POS_BITS'(k))) begin
        rd_entry = rd_entry | entry_w[k];
      end
    end
  end

endmodule

/* rtl/core/sparse_gf2_column_add.sv */
// Sparse GF(2) column adder: sorted index chain plus result register and control.
// Depends on gf2c_pkg, gf2c_if, gf2c_chain and assert_macros.svh.
//
// The column lives in a row of 64 cells, one sorted row index each. Every
// transaction (clear, append, toggle, read) finishes in the cycle it is
// accepted: all cells compare the index at once and shift one place toward their
// neighbor, so one transaction per cycle is sustained while out_ch.ready holds.
// The result sits in an output register and appears the cycle after acceptance;
// a new transaction is taken in the same cycle the pending result is taken. The
// compare across the cell row and the match OR tree set the clock period.
// Entries need no clearing pass after reset: per-cell valid bits reset to zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sparse_gf2_column_add import gf2c_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gf2c_in_if.sink     in_ch,
  gf2c_out_if.source  out_ch
);

  logic      in_acc;
  gf2c_cmd_t cmd;
  logic      found, first_valid, full, empty, app_ok, ovf_nxt;
  idx_t      last_entry, rd_entry;

  size_t count_r, count_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  rd_op_r, rd_op_nxt;
  pos_t  pos_r, pos_nxt;
  logic  ovf_r, ovf_r_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == SIZE_BITS'(MAX_ENTRIES));
  assign empty       = (count_r == '0);
  assign app_ok      = empty || (in_ch.entry_index > last_entry);

  always_comb begin
    cmd     = '0;
    ovf_nxt = 1'b0;
    if (in_acc) begin
      case (in_ch.opcode)
        OP_CLEAR: begin
          cmd.clr = 1'b1;
        end
        OP_APPEND: begin
          cmd.ins = app_ok && !full;
          ovf_nxt = app_ok && full;
        end
        OP_TOGGLE: begin
          cmd.del = found;
          cmd.ins = !found && !full;
          ovf_nxt = !found && full;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr) begin
      count_nxt = '0;
    end else if (cmd.ins) begin
      count_nxt = count_r + SIZE_BITS'(1);
    end else if (cmd.del) begin
      count_nxt = count_r - SIZE_BITS'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    rd_op_nxt     = rd_op_r;
    pos_nxt       = pos_r;
    ovf_r_nxt     = ovf_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      rd_op_nxt     = (in_ch.opcode == OP_READ);
      pos_nxt       = in_ch.position;
      ovf_r_nxt     = ovf_nxt;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  gf2c_chain u_chain (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .v           (in_ch.entry_index),
    .rd_pos      (pos_r),
    .found       (found),
    .first_valid (first_valid),
    .last_entry  (last_entry),
    .rd_entry    (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_op_r <= rd_op_nxt;
    pos_r   <= pos_nxt;
    ovf_r   <= ovf_r_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pivot      = empty ? '1 : {1'b0, last_entry};
  assign out_ch.size       = count_r;
  assign out_ch.read_value = rd_op_r ? rd_entry : '0;
  assign out_ch.overflow   = ovf_r;

  `GF2C_ASSERT(a_count_range, clk, rst_n, count_r <= SIZE_BITS'(MAX_ENTRIES), "count out of range")
  `GF2C_ASSERT(a_valid_count, clk, rst_n, empty == !first_valid, "valid bits disagree with count")
  `GF2C_ASSERT(a_ovf_full, clk, rst_n, !(out_valid_r && ovf_r) || full, "overflow without full store")
  `GF2C_ASSERT_NEXT(a_clear, clk, rst_n, in_acc && (in_ch.opcode == OP_CLEAR), count_r == '0, "clear left entries")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for sparse_gf2_column_add: clear, append, toggle and read traffic.
// Depends on gf2c_pkg and gf2c_if; predicts every result from its own model of the column.
`timescale 1ns / 1ps

module tb_top;
  import gf2c_pkg::*;

  typedef struct packed {
    logic [1:0] op;
    idx_t       idx;
    pos_t       pos;
    logic       hold;
  } col_op_t;

  typedef struct packed {
    logic signed [PIVOT_BITS-1:0] pivot;
    size_t                        size;
    idx_t                         read_value;
    logic                         overflow;
  } col_result_t;

  localparam int RANDOM_ITEMS = 750;
  localparam int REPORT_LIMIT = 10;

  logic clk;
  logic rst_n;

  gf2c_in_if  in_ch ();
  gf2c_out_if out_ch ();

  sparse_gf2_column_add u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  col_op_t     pending_ops[$];
  col_result_t expected_results[$];

  idx_t col_entries [MAX_ENTRIES];
  int   col_count;

  int sent_count;
  int accepted_count;
  int result_count;
  int fail_count;
  int random_items;
  int op_seen [4];
  int overflow_seen;
  int peak_size;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit quiet_window();
    return accepted_count >= 300 && accepted_count < 460;
  endfunction

  task automatic add_op(input logic [1:0] op, input int unsigned idx, input int unsigned pos,
                        input logic hold = 1'b0);
    col_op_t t;
    t.op   = op;
    t.idx  = idx_t'(idx);
    t.pos  = pos_t'(pos);
    t.hold = hold;
    pending_ops = {pending_ops, t};
    if (random_items >= 0) random_items++;
  endtask

  task automatic maybe_read();
    if ($urandom_range(0, 99) < 15) add_op(OP_READ, $urandom, $urandom_range(0, 63));
  endtask

  task automatic column_step(input logic [1:0] op, input idx_t idx, input pos_t pos,
                             output col_result_t r);
    int   i;
    int   j;
    logic ovf;
    idx_t rd;
    ovf = 1'b0;
    rd  = '0;
    case (op)
      OP_CLEAR: col_count = 0;
      OP_APPEND: begin
        if (col_count == 0 || idx > col_entries[col_count-1]) begin
          if (col_count >= MAX_ENTRIES) begin
            ovf = 1'b1;
          end else begin
            col_entries[col_count] = idx;
            col_count++;
          end
        end
      end
      OP_TOGGLE: begin
        i = 0;
        while (i < col_count && col_entries[i] < idx) i++;
        if (i < col_count && col_entries[i] == idx) begin
          for (j = i; j < col_count - 1; j++) col_entries[j] = col_entries[j+1];
          col_count--;
        end else if (col_count >= MAX_ENTRIES) begin
          ovf = 1'b1;
        end else begin
          for (j = col_count; j > i; j--) col_entries[j] = col_entries[j-1];
          col_entries[i] = idx;
          col_count++;
        end
      end
      default: begin
        if (int'(pos) < col_count) rd = col_entries[pos];
      end
    endcase
    r.pivot      = (col_count == 0) ? '1 : {1'b0, col_entries[col_count-1]};
    r.size       = size_t'(col_count);
    r.read_value = rd;
    r.overflow   = ovf;
  endtask

  // load 64 ascending entries, then push past capacity at the top of the index range
  task automatic gen_full_column();
    int unsigned loaded [MAX_ENTRIES];
    int k;
    add_op(OP_CLEAR, $urandom, $urandom, 1'b1);
    for (k = 0; k < MAX_ENTRIES; k++) begin
      loaded[k] = k * 16000 + $urandom_range(0, 15999);
      add_op(OP_APPEND, loaded[k], $urandom);
    end
    add_op(OP_APPEND, 20'hFFFFF, $urandom);
    add_op(OP_TOGGLE, 20'hFFFFF, $urandom);
    add_op(OP_TOGGLE, loaded[20], $urandom);
    add_op(OP_TOGGLE, 20'hFFFFF, $urandom);
    add_op(OP_READ, $urandom, 63);
    add_op(OP_READ, $urandom, 0);
    add_op(OP_APPEND, 20'hFFFFF, $urandom);
    add_op(OP_TOGGLE, loaded[20], $urandom);
    add_op(OP_TOGGLE, loaded[0], $urandom);
    add_op(OP_READ, $urandom, 62);
  endtask

  task automatic gen_column_episode();
    int unsigned loaded [MAX_ENTRIES];
    int unsigned v;
    int unsigned base;
    int unsigned span;
    int k;
    int n;
    int m;
    bit narrow;
    narrow = ($urandom_range(0, 9) < 7);
    k = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 64) : $urandom_range(1, 20);
    m = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 50) : $urandom_range(1, 20);
    add_op(OP_CLEAR, $urandom, $urandom);
    if (narrow) begin
      base = $urandom_range(0, 20'hFFFFF - 600);
      v = base;
      for (n = 0; n < k; n++) begin
        add_op(OP_APPEND, v, $urandom);
        maybe_read();
        v += $urandom_range(1, 4);
      end
      v = base + $urandom_range(0, 3);
      for (n = 0; n < m; n++) begin
        add_op(OP_TOGGLE, v, $urandom);
        maybe_read();
        v += $urandom_range(1, 4);
      end
    end else begin
      span = (1 << INDEX_BITS) / (k + 1);
      v = $urandom_range(0, span);
      n = 0;
      while (n < k && v <= 20'hFFFFF) begin
        loaded[n] = v;
        add_op(OP_APPEND, v, $urandom);
        maybe_read();
        v += $urandom_range(1, span);
        n++;
      end
      k = n;
      for (n = 0; n < m; n++) begin
        if (k > 0 && $urandom_range(0, 1) == 1) add_op(OP_TOGGLE, loaded[$urandom_range(0, k-1)],
                                                      $urandom);
        else add_op(OP_TOGGLE, $urandom, $urandom);
        maybe_read();
      end
    end
    for (n = 0; n < 3; n++) add_op(OP_READ, $urandom, $urandom_range(0, 63));
  endtask

  task automatic gen_noise();
    int n;
    for (n = 0; n < 10; n++) add_op(2'($urandom_range(0, 3)), $urandom, $urandom);
  endtask

  task automatic gen_broken_load();
    int unsigned v;
    int n;
    v = $urandom_range(1000, 20'hFFFFF);
    add_op(OP_CLEAR, $urandom, $urandom);
    for (n = 0; n < 8; n++) begin
      add_op(OP_APPEND, v, $urandom);
      if ($urandom_range(0, 1) == 1) v = v - $urandom_range(0, 999);
      else v = v + $urandom_range(1, 999);
      if (v > 20'hFFFFF) v = 20'hFFFFF;
    end
    add_op(OP_READ, $urandom, $urandom_range(0, 8));
  endtask

  // drive the input channel at the falling edge
  always @(negedge clk) begin : drive_in
    col_op_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && accepted_count != sent_count)) begin
      if (pending_ops.size() == 0 || (!quiet_window() && $urandom_range(0, 99) < 6)) begin
        in_ch.valid <= 1'b0;
      end else if (pending_ops[0].hold && expected_results.size() != 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        nxt = pending_ops.pop_front();
        in_ch.opcode      <= nxt.op;
        in_ch.entry_index <= nxt.idx;
        in_ch.position    <= nxt.pos;
        in_ch.valid       <= 1'b1;
        sent_count++;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= quiet_window() || ($urandom_range(0, 99) >= 6);
  end

  // predict the result of every accepted transaction
  always @(posedge clk) begin : predict_in
    col_result_t r;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      column_step(in_ch.opcode, in_ch.entry_index, in_ch.position, r);
      expected_results = {expected_results, r};
      accepted_count++;
      op_seen[in_ch.opcode]++;
      if (r.overflow) overflow_seen++;
      if (col_count > peak_size) peak_size = col_count;
    end
  end

  always @(posedge clk) begin : check_out
    col_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: pivot %0d size %0d read %h ovf %b",
                   out_ch.pivot, out_ch.size, out_ch.read_value, out_ch.overflow);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.pivot !== want.pivot || out_ch.size !== want.size ||
            out_ch.read_value !== want.read_value || out_ch.overflow !== want.overflow) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch at result %0d: expected pivot %0d size %0d read %h ovf %b",
                     result_count, want.pivot, want.size, want.read_value, want.overflow);
            $display("  got pivot %0d size %0d read %h ovf %b",
                     out_ch.pivot, out_ch.size, out_ch.read_value, out_ch.overflow);
          end
        end
      end
    end
  end

  initial begin : run_ctrl
    int n;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_CLEAR;
    in_ch.entry_index = '0;
    in_ch.position    = '0;
    out_ch.ready      = 1'b0;
    col_count         = 0;
    sent_count        = 0;
    accepted_count    = 0;
    result_count      = 0;
    fail_count        = 0;
    overflow_seen     = 0;
    peak_size         = 0;
    for (n = 0; n < 4; n++) op_seen[n] = 0;
    for (n = 0; n < MAX_ENTRIES; n++) col_entries[n] = '0;

    random_items = -1;
    add_op(OP_READ, 20'hFFFFF, 0);
    add_op(OP_TOGGLE, 0, 6'h3F);
    add_op(OP_APPEND, 20'hFFFFF, 0);
    add_op(OP_APPEND, 5, 6'h15);
    add_op(OP_APPEND, 20'hFFFFF, 6'h2A);
    add_op(OP_READ, 0, 0);
    add_op(OP_READ, 20'h55555, 1);
    add_op(OP_READ, 20'hAAAAA, 63);
    add_op(OP_TOGGLE, 20'h80000, 0);
    add_op(OP_READ, 0, 1);
    add_op(OP_TOGGLE, 20'h80000, 0);
    add_op(OP_TOGGLE, 20'hFFFFF, 0);
    add_op(OP_TOGGLE, 0, 0);
    add_op(OP_APPEND, 20'h55555, 6'h2A);
    add_op(OP_CLEAR, 20'hFFFFF, 6'h3F);
    add_op(OP_READ, 20'hFFFFF, 0);
    add_op(OP_APPEND, 1, 6'h3F);
    add_op(OP_APPEND, 0, 0);
    add_op(OP_READ, 0, 0);
    add_op(OP_CLEAR, 0, 0);

    random_items = 0;
    gen_full_column();
    while (random_items < RANDOM_ITEMS) begin
      n = $urandom_range(0, 9);
      if (n < 7) begin
        gen_column_episode();
      end else if (n == 7) begin
        gen_noise();
      end else if (n == 8) begin
        gen_broken_load();
      end else begin
        add_op(OP_READ, $urandom, $urandom_range(0, 63), 1'b1);
        gen_column_episode();
      end
    end
    n = pending_ops.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (pending_ops.size() == 0 && accepted_count == n);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) fail_count++;

    $display("%0d transactions (%0d clear, %0d append, %0d toggle, %0d read), %0d results",
             accepted_count, op_seen[OP_CLEAR], op_seen[OP_APPEND], op_seen[OP_TOGGLE],
             op_seen[OP_READ], result_count);
    $display("dropped inserts on a full column: %0d, peak column size %0d, failures %0d",
             overflow_seen, peak_size, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/gf2c_pkg.sv
rtl/core/gf2c_if.sv
rtl/core/gf2c_cell.sv
rtl/core/gf2c_chain.sv
rtl/core/sparse_gf2_column_add.sv
tb/tb_top.sv
